[src/tre_pkg.sv]
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types and constants of the threshold run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tre_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int LEVEL_W    = 8;
  localparam int DIM_W      = 13;
  localparam int RUN_W      = 12;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST    = 8'd128;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST    = 8'd255;
  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
  } tre_cfg_t;

  typedef struct packed {
    logic in_band;
    logic last_col;
  } tre_cls_t;

endpackage

`default_nettype wire

[src/tre_if.sv]
// ----------------------------------------------------------------------------
// tre_if
// Valid/ready channels of the encoder: pixel requests in, run requests out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tre_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface tre_run_if;
  logic        valid;
  logic        ready;
  logic [11:0] run_row;
  logic [11:0] run_first;
  logic [11:0] run_last;

  modport source (output valid, output run_row, output run_first, output run_last,
                  input ready);
  modport sink   (input valid, input run_row, input run_first, input run_last,
                  output ready);
endinterface

`default_nettype wire

[src/tre_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tre_cfg_regs
// APB-style register file holding the band levels and image size.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_cfg_regs
  import tre_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output tre_cfg_t                   cfg
);

  tre_cfg_t               cfg_r;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_level    <= MIN_LEVEL_RST;
      cfg_r.max_level    <= MAX_LEVEL_RST;
      cfg_r.image_width  <= IMAGE_WIDTH_RST;
      cfg_r.image_height <= IMAGE_HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_LEVEL:    cfg_r.min_level    <= pwdata[LEVEL_W-1:0];
        REG_MAX_LEVEL:    cfg_r.max_level    <= pwdata[LEVEL_W-1:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_LEVEL:    prdata = CFG_DATA_W'(cfg_r.min_level);
      REG_MAX_LEVEL:    prdata = CFG_DATA_W'(cfg_r.max_level);
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(cfg_r.image_height);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/tre_front.sv]
// ----------------------------------------------------------------------------
// tre_front
// Accepts pixels, classifies them against the band and tracks column and row.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_front
  import tre_pkg::*;
#(
  parameter  int MAX_DIM = MAX_DIM_DEF,
  localparam int CW      = $clog2(MAX_DIM)
)
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  tre_pixel_if.sink    in_pix,
  input  wire tre_cfg_t cfg,
  output logic         push_valid,
  input  wire logic    push_ready,
  output tre_cls_t     push_cls,
  output logic [CW-1:0] push_col,
  output logic [CW-1:0] push_row
);

  localparam int DW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);
  localparam logic [DW-1:0] ONE     = DW'(1);

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [DW-1:0] width_cl, height_cl;
  logic [DW-1:0] iw, ih;
  logic          accept;
  logic          last_col;
  logic          last_row;
  logic          in_band;

  assign iw = DW'(cfg.image_width);
  assign ih = DW'(cfg.image_height);

  always_comb begin
    if (iw == '0) begin
      width_cl = ONE;
    end else if (iw > DIM_MAX) begin
      width_cl = DIM_MAX;
    end else begin
      width_cl = iw;
    end
    if (ih == '0) begin
      height_cl = ONE;
    end else if (ih > DIM_MAX) begin
      height_cl = DIM_MAX;
    end else begin
      height_cl = ih;
    end
  end

  assign last_col = (DW'(col_r) + ONE) >= width_cl;
  assign last_row = (DW'(row_r) + ONE) >= height_cl;
  assign in_band  = (in_pix.pixel >= cfg.min_level) && (in_pix.pixel <= cfg.max_level);

  assign push_valid      = in_pix.valid;
  assign in_pix.ready    = push_ready;
  assign accept          = in_pix.valid & push_ready;
  assign push_cls.in_band  = in_band;
  assign push_cls.last_col = last_col;
  assign push_col        = col_r;
  assign push_row        = row_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

[src/tre_queue.sv]
// ----------------------------------------------------------------------------
// tre_queue
// Two-entry queue between the classifying front and the run-building back.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_queue #(
  parameter int W = 8
)
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  logic [1:0]   count_r, count_nxt;
  logic [W-1:0] ent0_r;
  logic [W-1:0] ent1_r;
  logic         push;
  logic         pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = ent0_r;
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count_r == 2'd2) begin
        ent0_r <= ent1_r;
      end else if (push) begin
        ent0_r <= push_data;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        ent0_r <= push_data;
      end else begin
        ent1_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

[src/tre_back.sv]
// ----------------------------------------------------------------------------
// tre_back
// Tracks the open run and loads finished runs into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tre_back
  import tre_pkg::*;
#(
  parameter  int MAX_DIM = MAX_DIM_DEF,
  localparam int CW      = $clog2(MAX_DIM)
)
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  output logic               head_pop,
  input  wire tre_cls_t      head_cls,
  input  wire logic [CW-1:0] head_col,
  input  wire logic [CW-1:0] head_row,
  tre_run_if.source          out_run
);

  localparam int EW = (CW > RUN_W) ? CW : RUN_W;

  logic             in_run_r, in_run_nxt;
  logic [CW-1:0]    run_start_r, run_start_nxt;
  logic             out_valid_r;
  logic [RUN_W-1:0] row_r, first_r, last_r;
  logic             run_open;
  logic             emit;
  logic [CW-1:0]    emit_first, emit_last;
  logic [EW-1:0]    ext_row, ext_first, ext_last;

  assign head_pop = head_valid & (~out_valid_r | out_run.ready);
  assign run_open = in_run_r & (head_col != '0);

  always_comb begin
    in_run_nxt    = run_open;
    run_start_nxt = run_start_r;
    emit          = 1'b0;
    emit_first    = run_start_r;
    emit_last     = head_col;
    if (head_cls.in_band) begin
      if (!run_open) begin
        emit_first    = head_col;
        run_start_nxt = head_col;
      end
      if (head_cls.last_col) begin
        emit       = 1'b1;
        in_run_nxt = 1'b0;
      end else begin
        in_run_nxt = 1'b1;
      end
    end else if (run_open) begin
      emit       = 1'b1;
      emit_last  = head_col - CW'(1);
      in_run_nxt = 1'b0;
    end
  end

  assign ext_row   = EW'(head_row);
  assign ext_first = EW'(emit_first);
  assign ext_last  = EW'(emit_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r    <= 1'b0;
      run_start_r <= '0;
      out_valid_r <= 1'b0;
    end else if (head_pop) begin
      in_run_r    <= in_run_nxt;
      run_start_r <= run_start_nxt;
      out_valid_r <= emit;
    end else if (out_run.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop && emit) begin
      row_r   <= ext_row[RUN_W-1:0];
      first_r <= ext_first[RUN_W-1:0];
      last_r  <= ext_last[RUN_W-1:0];
    end
  end

  assign out_run.valid     = out_valid_r;
  assign out_run.run_row   = row_r;
  assign out_run.run_first = first_r;
  assign out_run.run_last  = last_r;

endmodule

`default_nettype wire

[src/threshold_run_length_encoder.sv]
// ----------------------------------------------------------------------------
// threshold_run_length_encoder
// Grey pixels in raster order in, runs of in-band pixels out.
//
// in_pix carries one 8-bit pixel per request; out_run carries one run per
// request as row, first column and last column, both inclusive. A run ends at
// the first pixel outside [min_level, max_level] or at the last column of a
// row. The APB port sets the band and the image size; write it while idle.
// Throughput is one pixel per cycle while out_run does not stall, set by the
// compare and counter step of the front. A run appears on out_run once the
// pixel that closes it has been written into the two-entry queue and the run
// builder has popped it from the head and loaded the output register. When
// out_run stalls the output register holds its run, the queue fills and
// in_pix.ready falls once two pixels wait in it. Reset restores the register
// defaults, clears the column and row counters, closes any open run and
// empties the queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_run_length_encoder
  import tre_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tre_pixel_if.sink                  in_pix,
  tre_run_if.source                  out_run,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int QW = $bits(tre_cls_t) + 2 * CW;

  tre_cfg_t      cfg;
  logic          q_push_valid;
  logic          q_push_ready;
  tre_cls_t      f_cls;
  logic [CW-1:0] f_col;
  logic [CW-1:0] f_row;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;
  logic          q_head_valid;
  logic          q_pop;
  tre_cls_t      b_cls;
  logic [CW-1:0] b_col;
  logic [CW-1:0] b_row;

  tre_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tre_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg        (cfg),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cls   (f_cls),
    .push_col   (f_col),
    .push_row   (f_row)
  );

  assign q_in = {f_cls, f_col, f_row};

  tre_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_in),
    .pop_valid  (q_head_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_out)
  );

  assign {b_cls, b_col, b_row} = q_out;

  tre_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_pop   (q_pop),
    .head_cls   (b_cls),
    .head_col   (b_col),
    .head_row   (b_row),
    .out_run    (out_run)
  );

`ifndef ASSERT_OFF
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_pix.ready)
    else $error("input not ready after reset");

  a_accept_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> q_head_valid)
    else $error("accepted pixel missing from queue");

  a_run_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_run.valid) |-> $past(q_pop))
    else $error("run raised without a queue pop");
`endif

endmodule

`default_nettype wire

[tb/tre_run_checker.sv]
// ----------------------------------------------------------------------------
// tre_run_checker
// Watches the pixel, run and APB traffic of the threshold run-length encoder.
// Keeps its own copy of the band and image size from observed APB writes,
// works out the run that each accepted pixel closes, and compares every
// accepted run, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module tre_run_checker
  import tre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tre_pixel_if                  pix,
  tre_run_if                    run,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    pending,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [RUN_W-1:0] run_row;
    logic [RUN_W-1:0] run_first;
    logic [RUN_W-1:0] run_last;
  } run_t;

  tre_cfg_t         band_cfg;
  logic             run_open;
  logic [RUN_W-1:0] open_start;
  logic [RUN_W-1:0] col_q;
  logic [RUN_W-1:0] row_q;
  run_t             runs_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("%0t: run mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic encode_pixel(input logic [PIX_W-1:0] p);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic        last_col;
    logic        in_band;
    run_t        r;
    w        = fit_dim(band_cfg.image_width);
    h        = fit_dim(band_cfg.image_height);
    c        = col_q;
    last_col = (c + 1 >= w);
    in_band  = (p >= band_cfg.min_level) && (p <= band_cfg.max_level);
    if (c == 0) run_open = 1'b0;
    if (in_band) begin
      if (!run_open) begin
        run_open   = 1'b1;
        open_start = RUN_W'(c);
      end
      if (last_col) begin
        r.run_row   = row_q;
        r.run_first = open_start;
        r.run_last  = RUN_W'(c);
        runs_due    = {runs_due, r};
        run_open = 1'b0;
      end
    end else if (run_open) begin
      r.run_row   = row_q;
      r.run_first = open_start;
      r.run_last  = RUN_W'(c - 1);
      runs_due    = {runs_due, r};
      run_open = 1'b0;
    end
    if (last_col) begin
      col_q = '0;
      row_q = (row_q + 1 >= h) ? '0 : row_q + 1'b1;
    end else begin
      col_q = RUN_W'(c + 1);
    end
  endtask

  task automatic check_run();
    run_t want;
    if (runs_due.size() == 0) begin
      report_mismatch($sformatf("unexpected run row %0d cols %0d..%0d",
                                run.run_row, run.run_first, run.run_last));
    end else begin
      want = runs_due.pop_front();
      if (run.run_row !== want.run_row)
        report_mismatch($sformatf("run_row got %0d want %0d", run.run_row, want.run_row));
      if (run.run_first !== want.run_first)
        report_mismatch($sformatf("run_first got %0d want %0d",
                                  run.run_first, want.run_first));
      if (run.run_last !== want.run_last)
        report_mismatch($sformatf("run_last got %0d want %0d", run.run_last, want.run_last));
    end
  endtask

  task automatic write_cfg();
    case (paddr[CFG_ADDR_W-1:2])
      REG_MIN_LEVEL:    band_cfg.min_level    = pwdata[LEVEL_W-1:0];
      REG_MAX_LEVEL:    band_cfg.max_level    = pwdata[LEVEL_W-1:0];
      REG_IMAGE_WIDTH:  band_cfg.image_width  = pwdata[DIM_W-1:0];
      REG_IMAGE_HEIGHT: band_cfg.image_height = pwdata[DIM_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      band_cfg.min_level    = MIN_LEVEL_RST;
      band_cfg.max_level    = MAX_LEVEL_RST;
      band_cfg.image_width  = IMAGE_WIDTH_RST;
      band_cfg.image_height = IMAGE_HEIGHT_RST;
      run_open   = 1'b0;
      open_start = '0;
      col_q      = '0;
      row_q      = '0;
      runs_due.delete();
    end else begin
      if (run.valid && run.ready) check_run();
      if (psel && penable && pwrite && pready) write_cfg();
      if (pix.valid && pix.ready) encode_pixel(pix.pixel);
    end
    pending <= runs_due.size();
  end

endmodule

[tb/threshold_run_length_encoder_tb.sv]
// ----------------------------------------------------------------------------
// threshold_run_length_encoder_tb
// Drives pixels and APB writes into the encoder and gives the verdict.
// A short directed pass covers the band edges, single-column runs, runs
// closed at the row end, clamped sizes, an empty band and a size change
// mid-row; random phases with bursty pixels, a stalling run sink and one
// phase at a width clamped to the largest size follow. Checking is done by
// tre_run_checker.
// ----------------------------------------------------------------------------
module threshold_run_length_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tre_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int SETTLE_CYCLES   = 6;
  localparam int RANDOM_ITEMS    = 1500;
  localparam int MODE_SPAN       = 200;
  localparam int WIDE_ITEMS      = 200;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    runs_pending;
  int                    fail_count;
  int                    burst_left = 0;
  int                    idle_cycles = 0;
  int                    rx_cyc = 0;
  bit                    hold_off_req = 1'b0;

  tre_pixel_if pix_if();
  tre_run_if   run_if();

  threshold_run_length_encoder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_run (run_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tre_run_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (pix_if),
    .run        (run_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (runs_pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (run_if.valid && run_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // run sink: free, random and patterned stalls, plus one long hold-off
  initial begin
    rx_mode_e mode;
    run_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        run_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        mode = rx_mode_e'((rx_cyc / MODE_SPAN) % 3);
        case (mode)
          RX_FREE:   run_if.ready <= 1'b1;
          RX_RANDOM: run_if.ready <= ($urandom_range(0, 9) >= 3);
          default:   run_if.ready <= (rx_cyc % 7 != 2) && (rx_cyc % 7 != 3);
        endcase
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= p;
    do @(posedge clk); while (!pix_if.ready);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_seq(input logic [PIX_W-1:0] s[$]);
    foreach (s[i]) send_pixel(s[i]);
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold pixels until every run is out and the pipe has drained, then write the band and size
  task automatic configure(input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi,
                           input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    pix_if.valid <= 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    set_reg(REG_MIN_LEVEL, CFG_DATA_W'(lo));
    set_reg(REG_MAX_LEVEL, CFG_DATA_W'(hi));
    set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    burst_left = 0;
  endtask

  task automatic random_phase(input int n, input bit hold, input bit wide);
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [PIX_W-1:0]   p;
    bit                 want_in;
    int                 pick;
    pick = $urandom_range(0, 9);
    lo   = LEVEL_W'($urandom_range(0, 255));
    hi   = LEVEL_W'($urandom_range(lo, 255));
    case (pick)
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = LEVEL_W'($urandom_range(1, 255));
        hi = LEVEL_W'($urandom_range(0, lo - 1));
      end
      2: lo = '0;
      3: hi = '1;
      default: ;
    endcase
    w = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2))
                                     : DIM_W'($urandom_range(3, 24));
    h = ($urandom_range(0, 7) == 0) ? '1 : DIM_W'($urandom_range(0, 6));
    if (wide) begin
      w = '1;
      h = DIM_W'(2);
    end
    configure(lo, hi, w, h);
    if (hold) hold_off_req = 1'b1;
    want_in = 1'b0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) want_in = !want_in;
      if (want_in && lo <= hi) p = PIX_W'($urandom_range(lo, hi));
      else p = PIX_W'($urandom_range(0, 255));
      send_pixel(p);
    end
  endtask

  initial begin
    int sent;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset band, then shrink the row under an open column count
    send_seq('{8'd128, 8'd255, 8'd127});
    configure(8'd10, 8'd20, 13'd4, 13'd2);
    send_seq('{8'd15, 8'd9, 8'd10, 8'd20, 8'd21, 8'd0, 8'd255, 8'd20, 8'd10,
               8'd15, 8'd0, 8'd15, 8'd0});
    configure(8'd0, 8'd0, 13'd0, 13'd0);
    send_seq('{8'd0, 8'd1, 8'd0});
    configure(8'd255, 8'd0, 13'd3, 13'h1FFF);
    send_seq('{8'd255, 8'd0, 8'd128});
    configure(8'd255, 8'd255, 13'd3, 13'h1FFF);
    send_seq('{8'd255, 8'd255, 8'd254});

    random_phase(150, 1'b1, 1'b0);
    random_phase(WIDE_ITEMS, 1'b0, 1'b1);
    sent = 150 + WIDE_ITEMS;
    while (sent < RANDOM_ITEMS) begin
      random_phase($urandom_range(60, 200), 1'b0, 1'b0);
      sent += 130;
    end

    pix_if.valid <= 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
